FILE: hw/rtl/hpe_pkg.sv
// hermite evaluator package: beat types, pipeline lane type, saturation helpers
// no dependencies; imported by every module of the evaluator
`timescale 1ns / 1ps
`default_nettype none

package hpe_pkg;

  // internal order width, covers every legal maximum order
  localparam int unsigned ORD_W = 5;

  localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

  // input beat
  typedef struct packed {
    logic [3:0]         order;
    logic signed [15:0] x_value;
  } hpe_in_t;

  // result beat
  typedef struct packed {
    logic signed [63:0] poly_value;
    logic signed [63:0] deriv_value;
    logic               overflow;
  } hpe_out_t;

  // recurrence state carried down the pipeline
  typedef struct packed {
    logic [ORD_W-1:0]   order;
    logic signed [15:0] x;
    logic signed [63:0] h_prev;
    logic signed [63:0] h_cur;
    logic               ovf;
  } hpe_lane_t;

  // saturation value for a given sign
  function automatic logic signed [63:0] sat_val(input logic neg);
    return neg ? VAL_MIN : VAL_MAX;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hpe_step.sv
// one recurrence step h_next = 2x*h_cur - 2k*h_prev in three register stages
// depends on hpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module hpe_step
  import hpe_pkg::*;
#(
  parameter int unsigned STEP_K      = 1,
  parameter int unsigned X_FRAC_BITS = 12
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      vld_i,
  input  wire hpe_lane_t lane_i,
  output logic           vld_o,
  output hpe_lane_t      lane_o
);

  localparam int unsigned PROD_SH = X_FRAC_BITS - 1;
  localparam logic signed [7:0] TWO_K = 8'(2 * STEP_K);
  localparam logic [ORD_W-1:0] K_ORD = ORD_W'(STEP_K);

  // stage 1: partial products of x*h_cur and the 2k*h_prev product
  logic               vld1_q, act1_q;
  hpe_lane_t          lane1_q;
  logic signed [48:0] pp_lo_q;
  logic signed [47:0] pp_hi_q;
  logic signed [71:0] t2p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane1_q <= lane_i;
      act1_q  <= lane_i.order > K_ORD;
      pp_lo_q <= 49'($signed({1'b0, lane_i.h_cur[31:0]})) * 49'(lane_i.x);
      pp_hi_q <= 48'($signed(lane_i.h_cur[63:32])) * 48'(lane_i.x);
      t2p_q   <= 72'(lane_i.h_prev) * 72'(TWO_K);
    end
  end

  // stage 2: join partials, floor shift, saturate both terms
  logic signed [79:0] prod, prod_sh;
  logic               t1_fit, t2_fit;
  logic               vld2_q, act2_q, ovf2_q;
  hpe_lane_t          lane2_q;
  logic signed [63:0] t1_q, t2_q;

  always_comb begin
    prod    = (80'(pp_hi_q) <<< 32) + 80'(pp_lo_q);
    prod_sh = prod >>> PROD_SH;
    t1_fit  = (&prod_sh[79:63]) | ~(|prod_sh[79:63]);
    t2_fit  = (&t2p_q[71:63]) | ~(|t2p_q[71:63]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane2_q <= lane1_q;
      act2_q  <= act1_q;
      t1_q    <= t1_fit ? prod_sh[63:0] : sat_val(prod_sh[79]);
      t2_q    <= t2_fit ? t2p_q[63:0] : sat_val(t2p_q[71]);
      ovf2_q  <= ~t1_fit | ~t2_fit;
    end
  end

  // stage 3: saturating difference and shift of the recurrence window
  logic signed [63:0] diff, h_next;
  logic               sub_ovf;
  hpe_lane_t          lane3_d, lane3_q;
  logic               vld3_q;

  always_comb begin
    diff    = t1_q - t2_q;
    sub_ovf = (t1_q[63] != t2_q[63]) && (diff[63] != t1_q[63]);
    h_next  = sub_ovf ? sat_val(t1_q[63]) : diff;
    lane3_d = lane2_q;
    if (act2_q) begin
      lane3_d.h_prev = lane2_q.h_cur;
      lane3_d.h_cur  = h_next;
      lane3_d.ovf    = lane2_q.ovf | ovf2_q | sub_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane3_q <= lane3_d;
    end
  end

  assign vld_o  = vld3_q;
  assign lane_o = lane3_q;

endmodule

`default_nettype wire

FILE: hw/rtl/hpe_deriv.sv
// derivative 2n*h_prev and result selection in two register stages
// depends on hpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module hpe_deriv
  import hpe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      vld_i,
  input  wire hpe_lane_t lane_i,
  output logic           vld_o,
  output hpe_out_t       res_o
);

  // stage 1: derivative product, pick the polynomial value
  logic               vld1_q, zero1_q, ovf1_q;
  logic signed [63:0] poly1_q;
  logic signed [71:0] dprod_q;
  logic               zero_ord;

  assign zero_ord = lane_i.order == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero1_q <= zero_ord;
      ovf1_q  <= lane_i.ovf;
      poly1_q <= zero_ord ? lane_i.h_prev : lane_i.h_cur;
      dprod_q <= 72'(lane_i.h_prev) * 72'($signed({2'b00, lane_i.order, 1'b0}));
    end
  end

  // stage 2: saturate the derivative, order zero gives a zero derivative
  logic     d_fit;
  logic     vld2_q;
  hpe_out_t res2_d, res2_q;

  always_comb begin
    d_fit              = (&dprod_q[71:63]) | ~(|dprod_q[71:63]);
    res2_d.poly_value  = poly1_q;
    res2_d.deriv_value = zero1_q ? 64'sd0 :
                         (d_fit ? dprod_q[63:0] : sat_val(dprod_q[71]));
    res2_d.overflow    = ovf1_q | (~zero1_q & ~d_fit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res2_q <= res2_d;
    end
  end

  assign vld_o = vld2_q;
  assign res_o = res2_q;

endmodule

`default_nettype wire

FILE: hw/rtl/hermite_polynomial_eval_unit.sv
// top level of the physicists' hermite polynomial evaluator
// depends on hpe_pkg, hpe_step, hpe_deriv
//
//   channel  | direction | handshake            | beat
//   ---------+-----------+----------------------+-----------------------------------
//   input    | in        | in_valid_i/in_ready_o | hpe_in_t  (order, x_value)
//   output   | out       | out_valid_o/out_ready_i | hpe_out_t (poly, deriv, overflow)
//
// one beat per cycle in steady state while the skid entry is empty; the stages are:
// one input register, three stages per recurrence step, two derivative
// stages and the output register. every beat runs through all steps, steps
// above its order pass it through. reset clears only the valid bits.
// the whole pipeline holds while the skid entry is full; in_ready_o is registered.
`timescale 1ns / 1ps
`default_nettype none

module hermite_polynomial_eval_unit
  import hpe_pkg::*;
#(
  parameter int unsigned MAX_ORDER       = 15,
  parameter int unsigned X_FRAC_BITS     = 12,
  parameter int unsigned VALUE_FRAC_BITS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire hpe_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output hpe_out_t     out_data_o
);

  localparam int INIT_SH = int'(VALUE_FRAC_BITS) - int'(X_FRAC_BITS) + 1;
  localparam int SH_L    = (INIT_SH >= 0) ? INIT_SH : 0;
  localparam int SH_R    = (INIT_SH < 0) ? -INIT_SH : 0;
  localparam logic signed [63:0] ONE_VAL = 64'sd1 <<< VALUE_FRAC_BITS;
  localparam logic [ORD_W-1:0]   MAX_ORD = ORD_W'(MAX_ORDER);

  logic      pipe_en;
  hpe_lane_t lane     [MAX_ORDER];
  logic      lane_vld [MAX_ORDER];

  // input stage: clamp the order, seed h_0 and h_1
  logic [ORD_W-1:0]   ord_ext;
  logic signed [63:0] x_ext;
  hpe_lane_t          lane0_d;

  always_comb begin
    ord_ext        = ORD_W'(in_data_i.order);
    x_ext          = 64'(in_data_i.x_value);
    lane0_d.order  = (ord_ext > MAX_ORD) ? MAX_ORD : ord_ext;
    lane0_d.x      = in_data_i.x_value;
    lane0_d.h_prev = ONE_VAL;
    lane0_d.h_cur  = (INIT_SH >= 0) ? (x_ext <<< SH_L) : (x_ext >>> SH_R);
    lane0_d.ovf    = 1'b0;
  end

  logic      vld0_q;
  hpe_lane_t lane0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (pipe_en) begin
      vld0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      lane0_q <= lane0_d;
    end
  end

  assign lane[0]     = lane0_q;
  assign lane_vld[0] = vld0_q;

  // recurrence steps k = 1 .. MAX_ORDER-1
  for (genvar k = 1; k < MAX_ORDER; k++) begin : g_step
    hpe_step #(
      .STEP_K      (k),
      .X_FRAC_BITS (X_FRAC_BITS)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .vld_i  (lane_vld[k-1]),
      .lane_i (lane[k-1]),
      .vld_o  (lane_vld[k]),
      .lane_o (lane[k])
    );
  end

  // derivative and result selection
  logic     res_vld;
  hpe_out_t res;

  hpe_deriv u_deriv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (lane_vld[MAX_ORDER-1]),
    .lane_i (lane[MAX_ORDER-1]),
    .vld_o  (res_vld),
    .res_o  (res)
  );

  // output register with one skid entry
  logic     out_vld_q, skid_vld_q;
  hpe_out_t out_q, skid_q;
  logic     take, arrive;

  assign pipe_en = ~skid_vld_q;
  assign take    = out_vld_q & out_ready_i;
  assign arrive  = pipe_en & res_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (take) begin
          skid_vld_q <= 1'b0;
        end
      end else if (arrive) begin
        if (out_vld_q && !take) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (arrive) begin
      if (out_vld_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_ready_o  = pipe_en;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/hpe_checker.sv
// port-level checker for the hermite evaluator, bound to the top level
// depends on hpe_pkg and hermite_polynomial_eval_unit
`timescale 1ns / 1ps
`default_nettype none

module hpe_checker
  import hpe_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire hpe_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire hpe_out_t out_data_o
);

  // beats in flight: accepted inputs minus delivered results
  logic       in_fire, out_fire;
  logic [7:0] cnt_d, cnt_q;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;
  assign cnt_d    = cnt_q + 8'(in_fire) - 8'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // input only backs up when a result is waiting
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // no result without an accepted input behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result beat without an accepted input");

  // x_value does not affect the flow; keep the input beat observed
  a_in_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.order == 4'd0) |=> cnt_q != '0)
    else $error("accepted beat not counted");

endmodule

bind hermite_polynomial_eval_unit hpe_checker u_hpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: dv/tb_hermite_polynomial_eval_unit.sv
// testbench for hermite_polynomial_eval_unit: directed and random beats checked
// against a bit-exact fixed-point predictor; depends on hpe_pkg and the rtl top
`timescale 1ns / 1ps

module tb_hermite_polynomial_eval_unit;
  import hpe_pkg::*;

  localparam int MAX_ORDER       = 15;
  localparam int X_FRAC_BITS     = 12;
  localparam int VALUE_FRAC_BITS = 16;
  localparam int LATENCY         = 3 * (MAX_ORDER - 1) + 4;
  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 7;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS     = 10;

  logic     clk_i = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  hpe_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b1;
  hpe_out_t out_data;

  hpe_out_t    pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        source_idle_en = 1'b1;
  logic        sink_idle_en = 1'b1;
  logic        sink_hold_req = 1'b0;

  hermite_polynomial_eval_unit #(
    .MAX_ORDER      (MAX_ORDER),
    .X_FRAC_BITS    (X_FRAC_BITS),
    .VALUE_FRAC_BITS(VALUE_FRAC_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // (a*b) >>> sh with floor rounding, saturated to 64 bits
  function automatic logic signed [63:0] mul_floor_sat(input logic signed [63:0] a,
                                                       input logic signed [31:0] b,
                                                       input int unsigned sh,
                                                       output logic sat_hit);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> sh;
    sat_hit = (prod[127:63] != {65{prod[127]}});
    if (sat_hit) begin
      return prod[127] ? VAL_MIN : VAL_MAX;
    end
    return prod[63:0];
  endfunction

  // a - b saturated to 64 bits
  function automatic logic signed [63:0] diff_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  output logic sat_hit);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    sat_hit = (d[64] != d[63]);
    if (sat_hit) begin
      return d[64] ? VAL_MIN : VAL_MAX;
    end
    return d[63:0];
  endfunction

  // H_n(x) and 2n*H_{n-1}(x) by the three-term recurrence
  function automatic hpe_out_t hermite_eval(input hpe_in_t beat);
    hpe_out_t           res;
    int                 n;
    int                 k;
    logic signed [63:0] xw;
    logic signed [31:0] xs;
    logic signed [63:0] h_lo;
    logic signed [63:0] h_hi;
    logic signed [63:0] t_x;
    logic signed [63:0] t_k;
    logic signed [63:0] h_nxt;
    logic               hit;
    logic               ovf;
    n = beat.order;
    if (n > MAX_ORDER) n = MAX_ORDER;
    xw = beat.x_value;
    xs = beat.x_value;
    ovf = 1'b0;
    h_lo = 64'sd1 <<< VALUE_FRAC_BITS;
    // 2x in value format, exact when widening, floor when narrowing
    if (VALUE_FRAC_BITS + 1 >= X_FRAC_BITS) begin
      h_hi = xw <<< (VALUE_FRAC_BITS + 1 - X_FRAC_BITS);
    end else begin
      h_hi = xw >>> (X_FRAC_BITS - VALUE_FRAC_BITS - 1);
    end
    if (n == 0) begin
      res.poly_value  = h_lo;
      res.deriv_value = '0;
    end else begin
      for (k = 1; k < n; k++) begin
        t_x = mul_floor_sat(h_hi, xs, X_FRAC_BITS - 1, hit);
        ovf |= hit;
        t_k = mul_floor_sat(h_lo, 2 * k, 0, hit);
        ovf |= hit;
        h_nxt = diff_sat(t_x, t_k, hit);
        ovf |= hit;
        h_lo = h_hi;
        h_hi = h_nxt;
      end
      res.poly_value  = h_hi;
      res.deriv_value = mul_floor_sat(h_lo, 2 * n, 0, hit);
      ovf |= hit;
    end
    res.overflow = ovf;
    return res;
  endfunction

  // random point: half within +-2.0, three in eight full range, one in eight near zero
  function automatic logic signed [15:0] rand_point();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel < 3) return 16'($urandom_range(0, 65535));
    if (sel < 7) return 16'(int'($urandom_range(0, 16383)) - 8192);
    return 16'(int'($urandom_range(0, 255)) - 128);
  endfunction

  // predict every accepted input beat
  always @(posedge clk_i) begin : input_monitor
    if (in_valid && in_ready) begin
      pending_results.push_back(hermite_eval(in_data));
    end
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    hpe_out_t want;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("unexpected result beat: poly %0d deriv %0d ovf %0b",
                   out_data.poly_value, out_data.deriv_value, out_data.overflow);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.poly_value !== want.poly_value ||
            out_data.deriv_value !== want.deriv_value ||
            out_data.overflow !== want.overflow) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch: poly exp %0d got %0d, deriv exp %0d got %0d, ovf exp %0b got %0b",
                     want.poly_value, out_data.poly_value, want.deriv_value,
                     out_data.deriv_value, want.overflow, out_data.overflow);
          end
        end
      end
    end
  end

  // output ready: random stall bursts, or one long hold on request
  initial begin : sink_ready_gen
    int unsigned burst;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk_i);
        sink_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // offer one beat and hold it until accepted
  task automatic send_beat(input logic [3:0] order, input logic signed [15:0] x);
    hpe_in_t beat;
    beat.order = order;
    beat.x_value = x;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // drop valid for a number of cycles
  task automatic source_pause(input int unsigned cycles);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // wait until every predicted result has come back
  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // every order at x = 1.0
  task automatic test_order_sweep();
    int o;
    for (o = 0; o <= 15; o++) send_beat(4'(o), 16'sd4096);
  endtask

  // extreme points, zero and one ulp, order zero and one
  task automatic test_field_extremes();
    send_beat(4'd15, 16'sh7FFF);
    send_beat(4'd15, 16'sh8000);
    send_beat(4'd0, 16'sh8000);
    send_beat(4'd1, 16'sh7FFF);
    send_beat(4'd1, 16'sh8000);
    send_beat(4'd7, 16'sd0);
    send_beat(4'd2, 16'sd1);
    send_beat(4'd3, -16'sd1);
  endtask

  // random beats, with sender gaps while enabled
  task automatic test_random_traffic(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if (source_idle_en && $urandom_range(0, 7) == 0) begin
        source_pause($urandom_range(1, 13));
      end
      send_beat(4'($urandom_range(0, 15)), rand_point());
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_backpressure();
    int unsigned k;
    source_pause(1);
    wait_results_drained();
    sink_hold_req = 1'b1;
    for (k = 0; k < 120; k++) send_beat(4'($urandom_range(0, 15)), rand_point());
  endtask

  // sender stops until the pipeline is empty, then resumes
  task automatic test_source_drain_pause();
    int unsigned k;
    for (k = 0; k < 40; k++) send_beat(4'($urandom_range(0, 15)), rand_point());
    source_pause(1);
    wait_results_drained();
    for (k = 0; k < 40; k++) send_beat(4'($urandom_range(0, 15)), rand_point());
  endtask

  // stimulus sequence and final verdict
  initial begin : main_seq
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    test_order_sweep();
    test_field_extremes();
    test_random_traffic(1300);
    test_output_backpressure();
    test_source_drain_pause();

    // last stretch runs at full rate on both sides
    source_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random_traffic(250);

    source_pause(1);
    wait_results_drained();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/hpe_pkg.sv
hw/rtl/hpe_step.sv
hw/rtl/hpe_deriv.sv
hw/rtl/hermite_polynomial_eval_unit.sv
hw/rtl/hpe_checker.sv
dv/tb_hermite_polynomial_eval_unit.sv
